@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of the ordered list engine.
// Depends on nothing; take it in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge, no reset gating
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// check on every rising edge while out of reset
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

@@ hdl/oale_pkg.sv @@
// Package of the ordered list engine: operation and status codes, cell command.
// Used by every module of the block; depends on nothing.
`default_nettype none

package oale_pkg;

  typedef enum logic [2:0] {
    KIND_APPEND = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_REMOVE = 3'd2,
    KIND_ERASE  = 3'd3,
    KIND_READ   = 3'd4,
    KIND_WRITE  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  localparam int POS_W    = 4;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 5;

  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic load_pos;
    logic load_cnt;
  } cell_cmd_t;

endpackage

`default_nettype wire

@@ hdl/oale_cell.sv @@
// One list cell: holds one entry and takes its value from a neighbor or the input word.
// Depends on oale_pkg for the broadcast cell command.
`default_nettype none

module oale_cell #(
  parameter int IDX         = 0,
  parameter int VALUE_WIDTH = 32,
  parameter int CMPW        = 5
) (
  input  wire logic                   clk,
  input  wire oale_pkg::cell_cmd_t    cmd,
  input  wire logic [CMPW-1:0]        pos,
  input  wire logic [CMPW-1:0]        cnt,
  input  wire logic [VALUE_WIDTH-1:0] wval,
  input  wire logic [VALUE_WIDTH-1:0] prev_d,
  input  wire logic [VALUE_WIDTH-1:0] next_d,
  output logic      [VALUE_WIDTH-1:0] q
);

  localparam logic [CMPW-1:0] IDX_C = CMPW'(IDX);

  logic [VALUE_WIDTH-1:0] entry_r;
  logic [VALUE_WIDTH-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    priority if (cmd.shift_up && (IDX_C > pos)) begin
      entry_nxt = prev_d;
    end else if ((cmd.shift_up || cmd.load_pos) && (IDX_C == pos)) begin
      entry_nxt = wval;
    end else if (cmd.load_cnt && (IDX_C == cnt)) begin
      entry_nxt = wval;
    end else if (cmd.shift_down && (IDX_C >= pos)) begin
      entry_nxt = next_d;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign q = entry_r;

endmodule

`default_nettype wire

@@ hdl/ordered_array_list_engine_top.sv @@
// Ordered list engine: a row of DEPTH cells, each shifting into its neighbor.
// Each accepted word's result word goes to the output register, which frees as it leaves.
// Throughput: one word per cycle, but none is taken while out_stall holds a result word.
// Reset (rst_n low, synchronous) empties the list and drops the pending result word.
// Cell contents have no reset; only entries below the count are ever read.
`default_nettype none

module ordered_array_list_engine_top #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [2:0]                    in_kind,
  input  wire logic [oale_pkg::POS_W-1:0]    in_position,
  input  wire logic signed [oale_pkg::DATA_W-1:0] in_item_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [oale_pkg::DATA_W-1:0] out_read_value,
  output logic [oale_pkg::STATUS_W-1:0]      out_status,
  output logic [oale_pkg::CNT_W-1:0]         out_entry_count
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > oale_pkg::POS_W) ? CW : oale_pkg::POS_W;
  localparam int NRD  = (DEPTH < (1 << oale_pkg::POS_W)) ? DEPTH : (1 << oale_pkg::POS_W);

  logic [CW-1:0]              count_r;
  logic [CW-1:0]              count_nxt;
  logic                       out_valid_r;
  logic signed [oale_pkg::DATA_W-1:0] rd_r;
  oale_pkg::status_t          status_r;
  logic [oale_pkg::CNT_W-1:0] cnt_out_r;

  logic                       in_acc;
  logic [CMPW-1:0]            pos_x;
  logic [CMPW-1:0]            cnt_x;
  logic                       full;
  logic                       rd_hit;
  oale_pkg::status_t          status_nxt;
  oale_pkg::cell_cmd_t        cmd;
  oale_pkg::cell_cmd_t        cmd_acc;
  logic [VALUE_WIDTH-1:0]     wval;
  logic [VALUE_WIDTH-1:0]     sel_q;
  logic [oale_pkg::DATA_W-1:0] sel_32;
  logic [oale_pkg::DATA_W-1:0] rd_nxt;
  logic [oale_pkg::CNT_W-1:0] cnt_out_nxt;
  logic [VALUE_WIDTH-1:0]     cell_q [DEPTH];

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign pos_x    = CMPW'(in_position);
  assign cnt_x    = CMPW'(count_r);
  assign full     = (count_r == CW'(DEPTH));

  generate
    if (VALUE_WIDTH < oale_pkg::DATA_W) begin : g_narrow
      assign wval   = in_item_value[VALUE_WIDTH-1:0];
      assign sel_32 = {{(oale_pkg::DATA_W - VALUE_WIDTH){1'b0}}, sel_q};
    end else if (VALUE_WIDTH == oale_pkg::DATA_W) begin : g_same
      assign wval   = in_item_value;
      assign sel_32 = sel_q;
    end else begin : g_wide
      assign wval   = {{(VALUE_WIDTH - oale_pkg::DATA_W){in_item_value[oale_pkg::DATA_W-1]}},
                       in_item_value};
      assign sel_32 = sel_q[oale_pkg::DATA_W-1:0];
    end
    if (CW >= oale_pkg::CNT_W) begin : g_cnt_trunc
      assign cnt_out_nxt = count_nxt[oale_pkg::CNT_W-1:0];
    end else begin : g_cnt_ext
      assign cnt_out_nxt = {{(oale_pkg::CNT_W - CW){1'b0}}, count_nxt};
    end
  endgenerate

  always_comb begin
    cmd        = '0;
    status_nxt = oale_pkg::ST_OK;
    count_nxt  = count_r;
    rd_hit     = 1'b0;
    unique case (oale_pkg::kind_t'(in_kind))
      oale_pkg::KIND_APPEND: begin
        if (full) begin
          status_nxt = oale_pkg::ST_FULL;
        end else begin
          cmd.load_cnt = 1'b1;
          count_nxt    = count_r + 1'b1;
        end
      end
      oale_pkg::KIND_INSERT: begin
        if (pos_x > cnt_x) begin
          status_nxt = oale_pkg::ST_RANGE;
        end else if (full) begin
          status_nxt = oale_pkg::ST_FULL;
        end else begin
          cmd.shift_up = 1'b1;
          count_nxt    = count_r + 1'b1;
        end
      end
      oale_pkg::KIND_REMOVE: begin
        if (count_r == '0) begin
          status_nxt = oale_pkg::ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      oale_pkg::KIND_ERASE: begin
        if (pos_x >= cnt_x) begin
          status_nxt = oale_pkg::ST_RANGE;
        end else begin
          cmd.shift_down = 1'b1;
          count_nxt      = count_r - 1'b1;
        end
      end
      oale_pkg::KIND_READ: begin
        if (pos_x >= cnt_x) begin
          status_nxt = oale_pkg::ST_RANGE;
        end else begin
          rd_hit = 1'b1;
        end
      end
      oale_pkg::KIND_WRITE: begin
        if (pos_x >= cnt_x) begin
          status_nxt = oale_pkg::ST_RANGE;
        end else begin
          cmd.load_pos = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign cmd_acc = in_acc ? cmd : '0;

  always_comb begin
    sel_q = '0;
    for (int i = 0; i < NRD; i++) begin
      if (in_position == oale_pkg::POS_W'(i)) begin
        sel_q = cell_q[i];
      end
    end
  end

  assign rd_nxt = rd_hit ? sel_32 : '0;

  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] prev_d;
      logic [VALUE_WIDTH-1:0] next_d;
      if (i == 0) begin : g_first
        assign prev_d = '0;
      end else begin : g_mid_lo
        assign prev_d = cell_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign next_d = cell_q[i];
      end else begin : g_mid_hi
        assign next_d = cell_q[i+1];
      end
      oale_cell #(
        .IDX         (i),
        .VALUE_WIDTH (VALUE_WIDTH),
        .CMPW        (CMPW)
      ) u_cell (
        .clk    (clk),
        .cmd    (cmd_acc),
        .pos    (pos_x),
        .cnt    (cnt_x),
        .wval   (wval),
        .prev_d (prev_d),
        .next_d (next_d),
        .q      (cell_q[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_r      <= rd_nxt;
      status_r  <= status_nxt;
      cnt_out_r <= cnt_out_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = rd_r;
  assign out_status      = status_r;
  assign out_entry_count = cnt_out_r;

endmodule

`default_nettype wire

@@ hdl/oale_checker.sv @@
// Port-level checks of the ordered list engine and the bind that attaches them.
// Depends on oale_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module oale_checker #(
  parameter int DEPTH = 16
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_read_value,
  input wire logic [1:0]  out_status,
  input wire logic [4:0]  out_entry_count
);

  `ASSERT_RST(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_read_value), "stalled result word changed")

  `ASSERT_RST(a_acc_gives_word, clk, rst_n, in_valid && !in_stall |=> out_valid, "accepted word produced no result word")

  `ASSERT_RST(a_read_only_ok, clk, rst_n, out_valid && (out_read_value != '0) |-> out_status == oale_pkg::ST_OK, "nonzero read value with error status")

  `ASSERT_RST(a_full_count, clk, rst_n, out_valid && (out_status == oale_pkg::ST_FULL) |-> out_entry_count == 5'(DEPTH), "list full reported below depth")

endmodule

bind ordered_array_list_engine_top oale_checker #(
  .DEPTH (DEPTH)
) u_oale_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_read_value  (out_read_value),
  .out_status      (out_status),
  .out_entry_count (out_entry_count)
);

`default_nettype wire
